// ----- src/gbff_pkg.sv -----
package gbff_pkg;

	localparam int GRID_SIDE_DEF = 64;

	localparam int CODE_W  = 3;
	localparam int COUNT_W = 13;
	localparam int COORD_W = 6;

	localparam logic [CODE_W-1:0] CODE_WALL      = 3'd4;
	localparam logic [CODE_W-1:0] CODE_UNREACHED = 3'd5;
	localparam logic [CODE_W-1:0] CODE_EMPTY     = 3'd6;
	localparam logic [CODE_W-1:0] CODE_NONE      = 3'd0;

	localparam logic [1:0] MODE_WRITE  = 2'd0;
	localparam logic [1:0] MODE_SEARCH = 2'd1;
	localparam logic [1:0] MODE_READ   = 2'd2;

	// neighbour order: row minus, column plus, row plus, column minus
	localparam logic [1:0] DIR_ROW_DN = 2'd0;
	localparam logic [1:0] DIR_COL_UP = 2'd1;
	localparam logic [1:0] DIR_ROW_UP = 2'd2;
	localparam logic [1:0] DIR_COL_DN = 2'd3;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_SWEEP,
		ST_TGT_RD,
		ST_TGT_CHK,
		ST_POP,
		ST_EXP,
		ST_FIN
	} state_t;

endpackage

// ----- src/grid_bfs_flow_field_core.sv -----
// channel  | signals                                   | direction
// ---------+-------------------------------------------+----------
// in       | in_valid, in_ready, mode, cell_x, cell_y,  | to core
//          | is_wall                                   |
// out      | out_valid, out_ready, cell_code,           | from core
//          | labelled_count                            |
//
// one transaction at a time; in_ready is high only while the sequencer is idle.
// a read waits for the registered cell memory read; a write does not.
// search: one sweep over 2^(2*clog2(GRID_SIDE)) cells (4096 at GRID_SIDE 64),
// then per queued cell a queue read plus four neighbour reads and a drain.
// after reset a clearing pass writes one cell per cycle before in_ready.
// a held result on out only stalls the finish of the next transaction.
module grid_bfs_flow_field_core
	import gbff_pkg::*;
#(
	parameter int GRID_SIDE = GRID_SIDE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         mode,
	input  logic [COORD_W-1:0] cell_x,
	input  logic [COORD_W-1:0] cell_y,
	input  logic               is_wall,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [CODE_W-1:0]  cell_code,
	output logic [COUNT_W-1:0] labelled_count
);

	localparam int CW         = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
	localparam int CAW        = 2 * CW;
	localparam int MEM_DEPTH  = 1 << CAW;
	localparam int CELL_TOTAL = GRID_SIDE * GRID_SIDE;
	localparam int QAW        = $clog2(CELL_TOTAL);
	localparam int QCW        = $clog2(CELL_TOTAL + 1);

	state_t state_q, state_d;

	// cell store, addressed by {row, column}
	logic [CODE_W-1:0] cell_mem [MEM_DEPTH];
	logic [CODE_W-1:0] cell_rd_q;
	logic              cell_we;
	logic [CAW-1:0]    cell_wa, cell_ra;
	logic [CODE_W-1:0] cell_wd;

	// frontier queue of cell addresses
	logic [CAW-1:0] q_mem [CELL_TOTAL];
	logic [CAW-1:0] q_rd_q;
	logic           q_we;

	logic [QCW-1:0]     head_q, tail_q;
	logic [CAW-1:0]     sw_q;
	logic               sw_done_q, sw_v_s1;
	logic [CAW-1:0]     sw_addr_s1;
	logic [2:0]         dir_q;
	logic               nb_v_s1;
	logic [CAW-1:0]     nb_addr_s1;
	logic [1:0]         nb_dir_s1;
	logic [CAW-1:0]     t_addr_q;
	logic               on_grid_q;
	logic [CODE_W-1:0]  res_code_q;
	logic [COUNT_W-1:0] count_q;
	logic               out_valid_q;
	logic [CODE_W-1:0]  out_code_q;
	logic [COUNT_W-1:0] out_count_q;

	logic           accept, on_grid_in, label;
	logic [CAW-1:0] acc_addr;
	logic [CW-1:0]  cur_x, cur_y, nb_x, nb_y;
	logic           nb_ok;

	assign accept     = in_valid && in_ready;
	assign on_grid_in = (9'(cell_x) < 9'(GRID_SIDE)) && (9'(cell_y) < 9'(GRID_SIDE));
	assign acc_addr   = {CW'(cell_x), CW'(cell_y)};
	assign cur_x      = q_rd_q[CAW-1:CW];
	assign cur_y      = q_rd_q[CW-1:0];
	assign label      = (state_q == ST_EXP) && nb_v_s1 && (cell_rd_q == CODE_UNREACHED);

	// neighbour of the cell being expanded, skipped when off the grid
	always_comb begin
		nb_x  = cur_x;
		nb_y  = cur_y;
		nb_ok = 1'b0;
		case (dir_q[1:0])
			DIR_ROW_DN: begin
				nb_x  = cur_x - 1'b1;
				nb_ok = cur_x != '0;
			end
			DIR_COL_UP: begin
				nb_y  = cur_y + 1'b1;
				nb_ok = cur_y != CW'(GRID_SIDE - 1);
			end
			DIR_ROW_UP: begin
				nb_x  = cur_x + 1'b1;
				nb_ok = cur_x != CW'(GRID_SIDE - 1);
			end
			DIR_COL_DN: begin
				nb_y  = cur_y - 1'b1;
				nb_ok = cur_y != '0;
			end
			default: nb_ok = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (sw_q == '1) state_d = ST_IDLE;
			ST_IDLE: begin
				if (in_valid) begin
					case (mode)
						MODE_SEARCH: state_d = ST_SWEEP;
						MODE_READ:   state_d = ST_READ;
						default:     state_d = ST_FIN;
					endcase
				end
			end
			ST_READ: state_d = ST_FIN;
			ST_SWEEP: begin
				if (sw_done_q && !sw_v_s1) state_d = on_grid_q ? ST_TGT_RD : ST_FIN;
			end
			ST_TGT_RD:  state_d = ST_TGT_CHK;
			ST_TGT_CHK: state_d = ST_POP;
			ST_POP:     state_d = (head_q == tail_q) ? ST_FIN : ST_EXP;
			ST_EXP:     if (dir_q[2]) state_d = ST_POP;
			ST_FIN:     if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	// memory port controls
	always_comb begin
		in_ready = state_q == ST_IDLE;
		cell_we  = 1'b0;
		cell_wa  = sw_q;
		cell_wd  = CODE_EMPTY;
		cell_ra  = acc_addr;
		q_we     = 1'b0;
		case (state_q)
			ST_CLEAR: cell_we = 1'b1;
			ST_IDLE: begin
				cell_we = accept && (mode == MODE_WRITE) && on_grid_in;
				cell_wa = acc_addr;
				cell_wd = is_wall ? CODE_WALL : CODE_EMPTY;
			end
			ST_SWEEP: begin
				cell_ra = sw_q;
				cell_we = sw_v_s1 && (cell_rd_q != CODE_WALL);
				cell_wa = sw_addr_s1;
				cell_wd = CODE_UNREACHED;
			end
			ST_TGT_RD: cell_ra = t_addr_q;
			ST_TGT_CHK: begin
				cell_we = cell_rd_q == CODE_UNREACHED;
				cell_wa = t_addr_q;
				cell_wd = {1'b0, DIR_ROW_DN};
				q_we    = 1'b1;
			end
			ST_EXP: begin
				cell_ra = {nb_x, nb_y};
				cell_we = label;
				cell_wa = nb_addr_s1;
				cell_wd = {1'b0, nb_dir_s1};
				q_we    = label;
			end
			default: cell_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cell_we) cell_mem[cell_wa] <= cell_wd;
		cell_rd_q <= cell_mem[cell_ra];
	end

	always_ff @(posedge clk) begin
		if (q_we) q_mem[tail_q[QAW-1:0]] <= (state_q == ST_TGT_CHK) ? t_addr_q : nb_addr_s1;
		if (state_q == ST_POP) q_rd_q <= q_mem[head_q[QAW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			sw_q        <= '0;
			sw_done_q   <= 1'b0;
			sw_v_s1     <= 1'b0;
			nb_v_s1     <= 1'b0;
			dir_q       <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_FIN && (!out_valid_q || out_ready)) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: sw_q <= sw_q + 1'b1;
				ST_IDLE: begin
					sw_q      <= '0;
					sw_done_q <= 1'b0;
					sw_v_s1   <= 1'b0;
					head_q    <= '0;
					tail_q    <= '0;
					if (accept) count_q <= '0;
				end
				ST_SWEEP: begin
					sw_v_s1 <= !sw_done_q;
					if (!sw_done_q) begin
						if (sw_q == '1) sw_done_q <= 1'b1;
						else sw_q <= sw_q + 1'b1;
					end
				end
				ST_TGT_CHK: begin
					tail_q <= tail_q + 1'b1;
					if (cell_rd_q == CODE_UNREACHED) count_q <= count_q + 1'b1;
				end
				ST_POP: begin
					dir_q   <= '0;
					nb_v_s1 <= 1'b0;
					if (head_q != tail_q) head_q <= head_q + 1'b1;
				end
				ST_EXP: begin
					dir_q   <= dir_q + 1'b1;
					nb_v_s1 <= !dir_q[2] && nb_ok;
					if (label) begin
						tail_q  <= tail_q + 1'b1;
						count_q <= count_q + 1'b1;
					end
				end
				default: sw_v_s1 <= 1'b0;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		sw_addr_s1 <= sw_q;
		nb_addr_s1 <= {nb_x, nb_y};
		nb_dir_s1  <= dir_q[1:0];
		if (accept) begin
			t_addr_q  <= acc_addr;
			on_grid_q <= on_grid_in;
			case (mode)
				MODE_WRITE:  res_code_q <= (on_grid_in && is_wall) ? CODE_WALL : CODE_EMPTY;
				MODE_SEARCH: res_code_q <= CODE_EMPTY;
				MODE_READ:   res_code_q <= CODE_EMPTY;
				default:     res_code_q <= CODE_NONE;
			endcase
		end
		if (state_q == ST_READ && on_grid_q) res_code_q <= cell_rd_q;
		// after the sweep the target is either a wall or unreached
		if (state_q == ST_TGT_CHK)
			res_code_q <= (cell_rd_q == CODE_UNREACHED) ? {1'b0, DIR_ROW_DN} : cell_rd_q;
		if (state_q == ST_FIN && (!out_valid_q || out_ready)) begin
			out_code_q  <= res_code_q;
			out_count_q <= count_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign cell_code      = out_code_q;
	assign labelled_count = out_count_q;

	a_head_behind_tail: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q)
		else $error("queue head passed tail");

	a_tail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q <= QCW'(CELL_TOTAL))
		else $error("frontier queue overflow");

	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second transaction taken while busy");

	a_cell_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		cell_we |-> (state_q == ST_CLEAR || state_q == ST_IDLE || state_q == ST_SWEEP ||
			state_q == ST_TGT_CHK || state_q == ST_EXP))
		else $error("cell store written outside a writing state");

	a_queue_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		q_we |-> (state_q == ST_TGT_CHK || state_q == ST_EXP))
		else $error("queue pushed outside the search");

endmodule

// ----- tb/sv/tb_grid_bfs_flow_field_core.sv -----
`timescale 1ns / 100ps

module tb_grid_bfs_flow_field_core
	import gbff_pkg::*;
();

	localparam int SIDE = GRID_SIDE_DEF;
	localparam int CELLS = SIDE * SIDE;
	localparam logic [1:0] MODE_NOP = 2'd3;
	localparam int RANDOM_PER_PHASE = 24;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN_CYCLES = 64;
	// must outlast the longest search and the clearing pass after reset
	localparam int QUIET_LIMIT = 120000;

	typedef struct packed {
		logic [1:0]         op;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               wall;
		logic               typed;
		logic [CODE_W-1:0]  code;
		logic [COUNT_W-1:0] cnt;
	} probe_t;

	typedef struct packed {
		logic [CODE_W-1:0]  code;
		logic [COUNT_W-1:0] cnt;
	} flow_result_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic [1:0]         mode;
	logic [COORD_W-1:0] cell_x;
	logic [COORD_W-1:0] cell_y;
	logic               is_wall;
	logic               out_valid;
	logic               out_ready;
	logic [CODE_W-1:0]  cell_code;
	logic [COUNT_W-1:0] labelled_count;

	logic [CODE_W-1:0] grid_codes [0:CELLS-1];
	flow_result_t      pending_results [$];
	int                send_idle_pct;
	int                recv_idle_pct;
	int                mismatches;
	bit                hold_req;

	grid_bfs_flow_field_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.cell_x         (cell_x),
		.cell_y         (cell_y),
		.is_wall        (is_wall),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.cell_code      (cell_code),
		.labelled_count (labelled_count)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic flow_result_t flow_field_step(input probe_t p);
		flow_result_t r;
		int tgt;
		int cur;
		int nx;
		int ny;
		int nb;
		int d;
		int bfs_frontier [CELLS];
		int fr_head;
		int fr_tail;
		r.code = CODE_NONE;
		r.cnt = '0;
		fr_head = 0;
		fr_tail = 0;
		tgt = int'(p.x) * SIDE + int'(p.y);
		case (p.op)
		MODE_WRITE: begin
			r.code = p.wall ? CODE_WALL : CODE_EMPTY;
			grid_codes[tgt] = r.code;
		end
		MODE_SEARCH: begin
			for (cur = 0; cur < CELLS; cur++)
				if (grid_codes[cur] != CODE_WALL)
					grid_codes[cur] = CODE_UNREACHED;
			// a wall target keeps its code but still seeds the frontier
			if (grid_codes[tgt] == CODE_UNREACHED) begin
				grid_codes[tgt] = CODE_NONE;
				r.cnt = r.cnt + 1'b1;
			end
			bfs_frontier[fr_tail] = tgt;
			fr_tail++;
			while (fr_head < fr_tail) begin
				cur = bfs_frontier[fr_head];
				fr_head++;
				for (d = 0; d < 4; d++) begin
					nx = cur / SIDE;
					ny = cur % SIDE;
					case (d[1:0])
					DIR_ROW_DN: nx = nx - 1;
					DIR_COL_UP: ny = ny + 1;
					DIR_ROW_UP: nx = nx + 1;
					DIR_COL_DN: ny = ny - 1;
					default: nx = -1;
					endcase
					if (nx >= 0 && ny >= 0 && nx < SIDE && ny < SIDE) begin
						nb = nx * SIDE + ny;
						if (grid_codes[nb] == CODE_UNREACHED) begin
							grid_codes[nb] = d[CODE_W-1:0];
							r.cnt = r.cnt + 1'b1;
							bfs_frontier[fr_tail] = nb;
							fr_tail++;
						end
					end
				end
			end
			r.code = grid_codes[tgt];
		end
		MODE_READ: begin
			r.code = grid_codes[tgt];
		end
		default: begin
			r.code = CODE_NONE;
		end
		endcase
		return r;
	endfunction

	function automatic probe_t row(input logic [1:0] op, input int x, input int y,
			input logic wall, input logic typed, input logic [CODE_W-1:0] code, input int cnt);
		probe_t p;
		p.op = op;
		p.x = COORD_W'(x);
		p.y = COORD_W'(y);
		p.wall = wall;
		p.typed = typed;
		p.code = code;
		p.cnt = COUNT_W'(cnt);
		return p;
	endfunction

	function automatic probe_t random_probe();
		probe_t p;
		int pick;
		p = '0;
		pick = $urandom_range(0, 99);
		p.x = COORD_W'($urandom_range(0, SIDE - 1));
		p.y = COORD_W'($urandom_range(0, SIDE - 1));
		p.wall = 1'($urandom_range(0, 1));
		if (pick < 40) begin
			p.op = MODE_WRITE;
			p.wall = ($urandom_range(0, 3) != 0);
			// half the writes land in the corner patches so searches meet a maze
			if ($urandom_range(0, 1)) begin
				p.x = COORD_W'($urandom_range(0, 7) + ($urandom_range(0, 1) ? 56 : 0));
				p.y = COORD_W'($urandom_range(0, 7) + ($urandom_range(0, 1) ? 56 : 0));
			end
		end else if (pick < 80) begin
			p.op = MODE_READ;
		end else if (pick < 90) begin
			p.op = MODE_SEARCH;
		end else begin
			p.op = MODE_NOP;
		end
		return p;
	endfunction

	task automatic offer(input probe_t p);
		flow_result_t want;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= p.op;
		cell_x <= p.x;
		cell_y <= p.y;
		is_wall <= p.wall;
		do @(posedge clk); while (!in_ready);
		want = flow_field_step(p);
		if (p.typed) begin
			want.code = p.code;
			want.cnt = p.cnt;
		end
		pending_results = {pending_results, want};
	endtask

	task automatic drain_pending();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	initial begin : receive_side
		flow_result_t want;
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected transaction, cell_code %0d labelled_count %0d",
						$time, cell_code, labelled_count);
					mismatches++;
				end else begin
					want = pending_results[0];
					pending_results.delete(0);
					if (cell_code !== want.code) begin
						$display("%0t: cell_code expected %0d got %0d", $time, want.code, cell_code);
						mismatches++;
					end
					if (labelled_count !== want.cnt) begin
						$display("%0t: labelled_count expected %0d got %0d",
							$time, want.cnt, labelled_count);
						mismatches++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		probe_t plan [$];
		int i;
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_WRITE;
		cell_x = '0;
		cell_y = '0;
		is_wall = 1'b0;
		mismatches = 0;
		hold_req = 1'b0;
		send_idle_pct = 22;
		recv_idle_pct = 82;
		for (i = 0; i < CELLS; i++)
			grid_codes[i] = CODE_EMPTY;

		plan = {plan, row(MODE_READ,    0,  0, 1'b0, 1'b1, CODE_EMPTY, 0)};
		plan = {plan, row(MODE_READ,   63, 63, 1'b0, 1'b1, CODE_EMPTY, 0)};
		plan = {plan, row(MODE_NOP,    63, 63, 1'b1, 1'b1, CODE_NONE, 0)};
		plan = {plan, row(MODE_WRITE,   0,  0, 1'b1, 1'b1, CODE_WALL, 0)};
		plan = {plan, row(MODE_WRITE,   0,  1, 1'b1, 1'b1, CODE_WALL, 0)};
		plan = {plan, row(MODE_WRITE,  63, 63, 1'b0, 1'b1, CODE_EMPTY, 0)};
		// search from a wall in the corner: spreads from its open neighbour
		plan = {plan, row(MODE_SEARCH,  0,  0, 1'b0, 1'b0, CODE_NONE, 0)};
		plan = {plan, row(MODE_READ,    0,  0, 1'b0, 1'b1, CODE_WALL, 0)};
		plan = {plan, row(MODE_READ,    1,  0, 1'b0, 1'b0, CODE_NONE, 0)};
		plan = {plan, row(MODE_READ,   63, 63, 1'b0, 1'b0, CODE_NONE, 0)};
		// box in the centre cell
		plan = {plan, row(MODE_WRITE,  31, 32, 1'b1, 1'b1, CODE_WALL, 0)};
		plan = {plan, row(MODE_WRITE,  32, 33, 1'b1, 1'b1, CODE_WALL, 0)};
		plan = {plan, row(MODE_WRITE,  33, 32, 1'b1, 1'b1, CODE_WALL, 0)};
		plan = {plan, row(MODE_WRITE,  32, 31, 1'b1, 1'b1, CODE_WALL, 0)};
		plan = {plan, row(MODE_SEARCH, 10, 10, 1'b0, 1'b0, CODE_NONE, 0)};
		plan = {plan, row(MODE_READ,   32, 32, 1'b0, 1'b1, CODE_UNREACHED, 0)};
		plan = {plan, row(MODE_SEARCH, 32, 32, 1'b0, 1'b1, CODE_NONE, 1)};
		plan = {plan, row(MODE_READ,   10, 10, 1'b0, 1'b1, CODE_UNREACHED, 0)};
		plan = {plan, row(MODE_WRITE,  32, 32, 1'b0, 1'b1, CODE_EMPTY, 0)};
		plan = {plan, row(MODE_READ,   32, 32, 1'b0, 1'b1, CODE_EMPTY, 0)};
		plan = {plan, row(MODE_SEARCH, 63,  0, 1'b0, 1'b0, CODE_NONE, 0)};
		plan = {plan, row(MODE_READ,    0, 63, 1'b0, 1'b0, CODE_NONE, 0)};
		plan = {plan, row(MODE_NOP,     0,  0, 1'b0, 1'b1, CODE_NONE, 0)};
		plan = {plan, row(MODE_WRITE,  63,  0, 1'b1, 1'b1, CODE_WALL, 0)};
		plan = {plan, row(MODE_SEARCH, 63, 63, 1'b0, 1'b0, CODE_NONE, 0)};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[k])
			offer(plan[k]);
		for (i = 0; i < RANDOM_PER_PHASE; i++)
			offer(random_probe());
		drain_pending();

		send_idle_pct = 82;
		recv_idle_pct = 22;
		for (i = 0; i < RANDOM_PER_PHASE; i++)
			offer(random_probe());
		drain_pending();

		// receiver holds off while short reads pile up behind the held result
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = 1'b1;
		repeat (4)
			offer(row(MODE_READ, $urandom_range(0, SIDE - 1), $urandom_range(0, SIDE - 1),
				1'b0, 1'b0, CODE_NONE, 0));
		for (i = 0; i < RANDOM_PER_PHASE; i++)
			offer(random_probe());
		drain_pending();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/gbff_pkg.sv
src/grid_bfs_flow_field_core.sv
tb/sv/tb_grid_bfs_flow_field_core.sv
